// ===== hw/rtl/kmm_pkg.sv =====
// ----------------------------------------------------------------------------
// kmm_pkg
// shared types and constants of the k-mismatch string matcher
// ----------------------------------------------------------------------------
package kmm_pkg;

  // defaults of the top level parameters
  localparam int MAX_PATTERN_DEF  = 16;
  localparam int MAX_MISMATCH_DEF = 7;
  localparam int COUNT_WIDTH_DEF  = 32;

  // fixed field widths
  localparam int BYTE_W      = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;
  localparam int LEN_W       = 5;
  localparam int LIM_W       = 3;
  localparam int OUT_COUNT_W = 32;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;

  // number of pattern characters held in the two pattern registers
  localparam int PATTERN_CHARS = 16;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LOW    = 2'd0,
    REG_PATTERN_HIGH   = 2'd1,
    REG_PATTERN_LENGTH = 2'd2,
    REG_MISMATCH_LIMIT = 2'd3
  } kmm_reg_t;

  // match settings handed to the back end
  typedef struct packed {
    logic [LEN_W-1:0] pattern_length;
    logic [LIM_W-1:0] mismatch_limit;
  } kmm_ctrl_t;

endpackage

// ===== hw/rtl/k_mismatch_string_matcher.sv =====
// ----------------------------------------------------------------------------
// k_mismatch_string_matcher
// streaming shift-add matcher: flags text windows within k mismatches
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake         | contents
//  ---------+-----+-------------------+--------------------------------------
//  s_*      | in  | s_tvalid/s_tready | text byte, tlast = end of text
//  m_*      | out | m_tvalid/m_tready | match flag + count, tlast = text done
//  cfg_*    | in  | cfg_we            | pattern, length, limit registers
//
//  one word per cycle sustained while the queue has room; an accepted word is
//  compared at the queue write, then the counter update registers it at m_*
//  the shift-add counter update sets the rate
//  rst (synchronous) clears the queue, saturates all counters, zeroes the
//  count and loads register defaults; no clearing pass
//  the 4-entry queue lets s_tready stay high while m_tready is low until
//  the queue fills; the output register is refilled in the cycle it is taken
//
module k_mismatch_string_matcher import kmm_pkg::*; #(
  parameter int MAX_PATTERN  = MAX_PATTERN_DEF,
  parameter int MAX_MISMATCH = MAX_MISMATCH_DEF,
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] text_byte
  input  logic                   s_tlast,   // end_of_text
  // result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [0] match_here, [32:1] match_count, zero fill
  output logic                   m_tlast,   // text_done
  // register writes
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // configuration registers
  logic [CFG_DATA_W-1:0] pattern_low;
  logic [CFG_DATA_W-1:0] pattern_high;
  logic [LEN_W-1:0]      pattern_length;
  logic [LIM_W-1:0]      mismatch_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= LEN_W'(1);
      mismatch_limit <= '0;
    end else if (cfg_we) begin
      case (kmm_reg_t'(cfg_index))
        REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        REG_MISMATCH_LIMIT: mismatch_limit <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  kmm_ctrl_t ctrl;
  assign ctrl.pattern_length = pattern_length;
  assign ctrl.mismatch_limit = mismatch_limit;

  // queue word: {end of text, per-position mismatch bits}
  logic                 q_push;
  logic                 q_full;
  logic                 q_pop;
  logic                 q_valid;
  logic [MAX_PATTERN:0] q_wdata;
  logic [MAX_PATTERN:0] q_rdata;

  kmm_front #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_front (
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .text_byte   (s_tdata[BYTE_W-1:0]),
    .end_of_text (s_tlast),
    .pattern     ({pattern_high, pattern_low}),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  kmm_fifo #(
    .WIDTH (MAX_PATTERN + 1)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  logic                   match_here;
  logic [OUT_COUNT_W-1:0] match_count;

  kmm_back #(
    .MAX_PATTERN  (MAX_PATTERN),
    .MAX_MISMATCH (MAX_MISMATCH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .q_valid     (q_valid),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .match_here  (match_here),
    .match_count (match_count),
    .text_done   (m_tlast)
  );

  // pack the result word, zero fill up to whole bytes
  assign m_tdata = {(OUT_TDATA_W - OUT_COUNT_W - 1)'(0), match_count, match_here};

endmodule

// ===== hw/rtl/kmm_front.sv =====
// ----------------------------------------------------------------------------
// kmm_front
// accepts text bytes and compares each against every pattern character
// ----------------------------------------------------------------------------
module kmm_front import kmm_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [BYTE_W-1:0]          text_byte,
  input  logic                       end_of_text,
  input  logic [2*CFG_DATA_W-1:0]    pattern,
  input  logic                       q_full,
  output logic                       q_push,
  output logic [MAX_PATTERN:0]       q_wdata
);

  logic [MAX_PATTERN-1:0] mismatch;

  // positions beyond the pattern registers compare against zero
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cmp
    if (j < PATTERN_CHARS) begin : g_reg
      assign mismatch[j] = (text_byte != pattern[BYTE_W*j +: BYTE_W]);
    end else begin : g_zero
      assign mismatch[j] = (text_byte != '0);
    end
  end

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;
  assign q_wdata  = {end_of_text, mismatch};

endmodule

// ===== hw/rtl/kmm_fifo.sv =====
// ----------------------------------------------------------------------------
// kmm_fifo
// short queue between the compare front and the counter back end
// ----------------------------------------------------------------------------
module kmm_fifo import kmm_pkg::*; #(
  parameter int WIDTH = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill level above depth");

endmodule

// ===== hw/rtl/kmm_back.sv =====
// ----------------------------------------------------------------------------
// kmm_back
// shift-add mismatch counters, match decision and occurrence count
// ----------------------------------------------------------------------------
module kmm_back import kmm_pkg::*; #(
  parameter int MAX_PATTERN  = MAX_PATTERN_DEF,
  parameter int MAX_MISMATCH = MAX_MISMATCH_DEF,
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  kmm_ctrl_t              ctrl,
  input  logic                   q_valid,
  input  logic [MAX_PATTERN:0]   q_rdata,
  output logic                   q_pop,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic                   match_here,
  output logic [OUT_COUNT_W-1:0] match_count,
  output logic                   text_done
);

  localparam int CW    = $clog2(MAX_MISMATCH + 2);
  localparam int IW    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LCW   = $clog2(MAX_PATTERN + 1) + 1;
  localparam int CMP_W = 9;
  localparam logic [CW-1:0] SAT = CW'(MAX_MISMATCH + 1);

  logic [CW-1:0]          cnt      [MAX_PATTERN];
  logic [CW-1:0]          cnt_next [MAX_PATTERN];
  logic [COUNT_WIDTH-1:0] occ;
  logic [COUNT_WIDTH-1:0] occ_base;
  logic [COUNT_WIDTH-1:0] occ_next;
  logic                   restart_pending;

  logic [MAX_PATTERN-1:0] mismatch;
  logic                   last;
  logic [LCW-1:0]         len_c;
  logic [IW-1:0]          sel;
  logic [CMP_W-1:0]       lim_c;
  logic                   hit;

  assign mismatch = q_rdata[MAX_PATTERN-1:0];
  assign last     = q_rdata[MAX_PATTERN];
  assign q_pop    = q_valid && (!m_tvalid || m_tready);

  // counter j takes counter j-1 plus this position's mismatch
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cnt
    logic [CW-1:0] prev;
    logic [CW:0]   sum;
    if (j == 0) begin : g_first
      assign prev = '0;
    end else begin : g_rest
      assign prev = restart_pending ? SAT : cnt[j-1];
    end
    assign sum         = {1'b0, prev} + (CW+1)'(mismatch[j]);
    assign cnt_next[j] = (sum > {1'b0, SAT}) ? SAT : sum[CW-1:0];
  end

  always_comb begin
    len_c = LCW'(ctrl.pattern_length);
    if (len_c == '0) begin
      len_c = LCW'(1);
    end else if (len_c > LCW'(MAX_PATTERN)) begin
      len_c = LCW'(MAX_PATTERN);
    end
    sel = IW'(len_c - LCW'(1));

    lim_c = CMP_W'(ctrl.mismatch_limit);
    if (lim_c > CMP_W'(MAX_MISMATCH)) begin
      lim_c = CMP_W'(MAX_MISMATCH);
    end

    hit      = (CMP_W'(cnt_next[sel]) <= lim_c);
    occ_base = restart_pending ? '0 : occ;
    occ_next = (hit && (occ_base != '1)) ? occ_base + 1'b1 : occ_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        cnt[j] <= SAT;
      end
      occ             <= '0;
      restart_pending <= 1'b1;
      m_tvalid        <= 1'b0;
    end else begin
      if (q_pop) begin
        for (int j = 0; j < MAX_PATTERN; j++) begin
          cnt[j] <= cnt_next[j];
        end
        occ             <= occ_next;
        restart_pending <= last;
        m_tvalid        <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      match_here  <= hit;
      match_count <= OUT_COUNT_W'(occ_next);
      text_done   <= last;
    end
  end

  a_restart_arm: assert property (@(posedge clk) disable iff (rst)
    q_pop && last |=> restart_pending)
    else $error("end of text did not arm a restart");

  a_restart_count: assert property (@(posedge clk) disable iff (rst)
    q_pop && restart_pending |=> occ <= COUNT_WIDTH'(1))
    else $error("count not cleared on restart");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    q_pop && !hit && !restart_pending |=> occ == $past(occ))
    else $error("count moved without a match");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the k-mismatch string matcher
// ----------------------------------------------------------------------------
// text bytes go in on the s_* stream and the bench keeps its own shift-add
// model of the mismatch counters and the match count. every accepted text
// word queues one expected result word, and each result word taken from m_*
// is checked field by field against the oldest one. directed tests come
// first, then a receiver hold-off, random phases with random patterns, and
// a last stretch with no idling on either side
// ----------------------------------------------------------------------------
module tb_top;
  import kmm_pkg::*;

  // a counter stuck at this level can never match
  localparam int SAT_LEVEL    = MAX_MISMATCH_DEF + 1;
  // block passes each word through the queue and the output register; leave slack
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 80;
  localparam int MAX_PRINTS   = 40;

  // one result word as the checker sees it
  typedef struct packed {
    logic                   done;
    logic [OUT_COUNT_W-1:0] count;
    logic                   hit;
  } match_word_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // [7:0] text_byte
  logic                   s_tlast;   // end_of_text
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // [0] match_here, [32:1] match_count, zero fill
  logic                   m_tlast;   // text_done
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // bench copy of the registers
  logic [CFG_DATA_W-1:0]  pat_lo;
  logic [CFG_DATA_W-1:0]  pat_hi;
  logic [LEN_W-1:0]       pat_len;
  logic [LIM_W-1:0]       mm_limit;

  // bench copy of the matcher state
  logic [3:0]             mm_count [PATTERN_CHARS];
  logic [OUT_COUNT_W-1:0] hit_total;
  logic                   restart_due;

  match_word_t            expected_words [$];
  int                     error_count;

  // idling controls for the sender and the receiver process
  bit                     sender_gaps;
  bit                     receiver_stalls;
  bit                     hold_request;

  k_mismatch_string_matcher u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // matcher model
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] pattern_char(int pos);
    if (pos < 8) return pat_lo[8*pos +: 8];
    return pat_hi[8*(pos-8) +: 8];
  endfunction

  // length 0 acts as 1, anything past the pattern store acts as full length
  function automatic int effective_length();
    if (pat_len == 0) return 1;
    if (pat_len > PATTERN_CHARS) return PATTERN_CHARS;
    return int'(pat_len);
  endfunction

  task automatic reset_matcher_model();
    int j;
    pat_lo      = '0;
    pat_hi      = '0;
    pat_len     = LEN_W'(1);
    mm_limit    = '0;
    hit_total   = '0;
    restart_due = 1'b1;
    for (j = 0; j < PATTERN_CHARS; j++) mm_count[j] = 4'(SAT_LEVEL);
  endtask

  // advance the counters by one text byte and return the result word
  function automatic match_word_t predict_match(logic [7:0] text_byte, logic eot);
    match_word_t w;
    logic [4:0]  sum;
    int          j;
    // first byte of a new text starts from empty windows and a zero count
    if (restart_due) begin
      for (j = 0; j < PATTERN_CHARS; j++) mm_count[j] = 4'(SAT_LEVEL);
      hit_total = '0;
    end
    // top down so each counter takes its lower neighbor's old value
    for (j = PATTERN_CHARS - 1; j >= 0; j--) begin
      sum = (j == 0) ? 5'd0 : {1'b0, mm_count[j-1]};
      if (text_byte != pattern_char(j)) sum = sum + 5'd1;
      mm_count[j] = (sum > SAT_LEVEL) ? 4'(SAT_LEVEL) : sum[3:0];
    end
    w.hit = ({1'b0, mm_count[effective_length()-1]} <= {2'b00, mm_limit});
    if (w.hit && hit_total != '1) hit_total = hit_total + 1'b1;
    w.count     = hit_total;
    w.done      = eot;
    restart_due = eot;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  // every result word taken at a rising edge is compared with the oldest
  // expectation; outputs are read before the edge's updates land
  always @(posedge clk) begin
    match_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = expected_words.pop_front();
        if (m_tdata[0] !== want.hit)
          report_mismatch($sformatf("match_here got %b want %b", m_tdata[0], want.hit));
        if (m_tdata[32:1] !== want.count)
          report_mismatch($sformatf("match_count got %0d want %0d",
                                    m_tdata[32:1], want.count));
        if (m_tlast !== want.done)
          report_mismatch($sformatf("text_done got %b want %b", m_tlast, want.done));
        if (m_tdata[OUT_TDATA_W-1:33] !== '0)
          report_mismatch($sformatf("fill bits got %h", m_tdata[OUT_TDATA_W-1:33]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stall bursts, or one long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin : receiver
    int stall;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        // long hold-off so the queue fills and s_tready drops
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
        m_tready = 1'b0;
        stall = $urandom_range(1, 13);
        repeat (stall - 1) @(negedge clk);
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offer one text word, maybe after an idle burst; valid stays high after
  // the handshake so back-to-back words keep a steady tvalid
  task automatic send_text_byte(logic [7:0] text_byte, logic eot);
    int gap;
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = text_byte;
    s_tlast  = eot;
    do @(posedge clk); while (!s_tready);
    expected_words.push_back(predict_match(text_byte, eot));
  endtask

  // stop offering, let every expected word come out, then let the pipe settle
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(kmm_reg_t idx, logic [CFG_DATA_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    case (idx)
      REG_PATTERN_LOW:    pat_lo   = value;
      REG_PATTERN_HIGH:   pat_hi   = value;
      REG_PATTERN_LENGTH: pat_len  = value[LEN_W-1:0];
      REG_MISMATCH_LIMIT: mm_limit = value[LIM_W-1:0];
      default: ;
    endcase
  endtask

  // pattern holds character 0 in its lowest byte
  task automatic load_setup(logic [127:0] pattern, int len, int lim);
    write_reg(REG_PATTERN_LOW, pattern[63:0]);
    write_reg(REG_PATTERN_HIGH, pattern[127:64]);
    write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
    write_reg(REG_MISMATCH_LIMIT, CFG_DATA_W'(lim));
  endtask

  // mostly pattern copies with a few damaged characters, between spacers
  // drawn from the pattern's own characters and the odd random byte
  task automatic send_pattern_text(int n_items, bit close_text);
    int         sent;
    int         pick;
    int         budget;
    int         len;
    int         j;
    logic [7:0] b;
    sent = 0;
    len  = effective_length();
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        // mismatch budget spans zero to one over the limit
        budget = $urandom_range(0, int'(mm_limit) + 1);
        for (j = 0; j < len; j++) begin
          b = pattern_char(j);
          if ($urandom_range(0, len - 1) < budget) begin
            b = b ^ 8'($urandom_range(1, 255));
            budget--;
          end
          send_text_byte(b, $urandom_range(0, 49) == 0);
          sent++;
        end
      end else if (pick < 9) begin
        send_text_byte(pattern_char($urandom_range(0, PATTERN_CHARS - 1)),
                       $urandom_range(0, 49) == 0);
        sent++;
      end else begin
        send_text_byte(8'($urandom_range(0, 255)), $urandom_range(0, 49) == 0);
        sent++;
      end
    end
    if (close_text) send_text_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // length and limit walk through their extremes as the phase number grows
  task automatic load_random_setup(int phase);
    logic [127:0] pattern;
    logic [7:0]   a0;
    logic [7:0]   a1;
    int           len;
    int           lim;
    int           j;
    if (phase % 3 == 0) begin
      // two-letter pattern so loose text still lands many matches
      a0 = 8'($urandom);
      a1 = 8'($urandom);
      for (j = 0; j < PATTERN_CHARS; j++) pattern[8*j +: 8] = $urandom_range(0, 1) ? a0 : a1;
    end else begin
      pattern = {$urandom, $urandom, $urandom, $urandom};
    end
    case (phase % 4)
      0:       len = 1;
      1:       len = PATTERN_CHARS;
      default: len = $urandom_range(1, PATTERN_CHARS);
    endcase
    case (phase % 5)
      0:       lim = 0;
      1:       lim = MAX_MISMATCH_DEF;
      default: lim = $urandom_range(0, MAX_MISMATCH_DEF);
    endcase
    load_setup(pattern, len, lim);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values: pattern of zero bytes, length 1, exact match only
  task automatic test_reset_defaults();
    send_text_byte(8'h00, 1'b0);
    send_text_byte(8'hff, 1'b0);
    send_text_byte(8'h00, 1'b1);
  endtask

  // overlapping exact hits, short windows at the start, and a fresh text
  // that must not see the tail of the one before
  task automatic test_exact_match();
    load_setup(128'h61_63_62_61, 4, 0);   // "abca"
    send_text_byte("a", 1'b0);
    send_text_byte("b", 1'b0);
    send_text_byte("c", 1'b0);
    send_text_byte("a", 1'b0);
    send_text_byte("b", 1'b0);
    send_text_byte("c", 1'b0);
    send_text_byte("a", 1'b1);
    send_text_byte("b", 1'b0);
    send_text_byte("c", 1'b0);
    send_text_byte("a", 1'b1);
  endtask

  // length 0 behaves as 1; an oversized length behaves as 16 and, with the
  // highest limit, a short text still never completes a window
  task automatic test_length_extremes();
    load_setup({64'h0, 64'hffff_ffff_ffff_ffff}, 0, 0);
    send_text_byte(8'hff, 1'b0);
    send_text_byte(8'h00, 1'b1);
    write_reg(REG_PATTERN_LENGTH, 64'd31);
    write_reg(REG_MISMATCH_LIMIT, 64'd7);
    send_text_byte(8'hff, 1'b0);
    send_text_byte(8'hff, 1'b0);
    send_text_byte(8'h00, 1'b1);
  endtask

  // settings change while a text is still open: counters and count carry on
  task automatic test_midtext_change();
    load_setup(128'h79_78, 2, 0);          // "xy"
    send_text_byte("x", 1'b0);
    send_text_byte("y", 1'b0);
    write_reg(REG_MISMATCH_LIMIT, 64'd1);
    send_text_byte("z", 1'b0);
    write_reg(REG_PATTERN_LENGTH, 64'd1);
    send_text_byte("x", 1'b1);
  endtask

  // receiver holds off while text keeps coming, so the block must stall
  task automatic test_backpressure();
    load_random_setup(2);
    sender_gaps  = 1'b0;
    hold_request = 1'b1;
    send_pattern_text(40, 1'b1);
    wait_idle();
    sender_gaps  = 1'b1;
  endtask

  // random patterns and settings; every other phase leaves its text open
  task automatic test_random_phases();
    int phase;
    for (phase = 0; phase < 16; phase++) begin
      load_random_setup(phase);
      send_pattern_text($urandom_range(70, 110), phase % 2 == 1);
    end
  endtask

  // last stretch at full rate on both sides
  task automatic test_full_rate();
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    load_random_setup(5);
    send_pattern_text(150, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst             = 1'b1;
    s_tvalid        = 1'b0;
    s_tdata         = '0;
    s_tlast         = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_PATTERN_LOW;
    cfg_data        = '0;
    error_count     = 0;
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    hold_request    = 1'b0;
    reset_matcher_model();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_exact_match();
    test_length_extremes();
    test_midtext_change();
    test_backpressure();
    test_random_phases();
    test_full_rate();

    wait_idle();
    if (error_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
